[src/cpu_8bit_instruction_core_top_assert.svh]
// Assertion macros for the CPU core checker
`ifndef CPU_8BIT_INSTRUCTION_CORE_TOP_ASSERT_SVH
`define CPU_8BIT_INSTRUCTION_CORE_TOP_ASSERT_SVH

// same-cycle implication
`define CPU8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPU8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cpu8_pkg.sv]
// Shared types, codes and ALU helpers of the CPU core
package cpu8_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;
  localparam logic [1:0] CMD_LDPC  = 2'd3;

  localparam int FB_C = 0;
  localparam int FB_Z = 1;
  localparam int FB_I = 2;
  localparam int FB_D = 3;
  localparam int FB_T = 5;
  localparam int FB_V = 6;
  localparam int FB_N = 7;

  localparam logic [7:0] OP_SXY = 8'h02;
  localparam logic [7:0] OP_SAX = 8'h22;
  localparam logic [7:0] OP_SAY = 8'h42;
  localparam logic [7:0] OP_CLA = 8'h62;
  localparam logic [7:0] OP_CLX = 8'h82;
  localparam logic [7:0] OP_CLY = 8'hC2;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;
  localparam logic [7:0] OP_SET = 8'hF4;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_BPL = 8'h10;
  localparam logic [7:0] OP_BMI = 8'h30;
  localparam logic [7:0] OP_BVC = 8'h50;
  localparam logic [7:0] OP_BVS = 8'h70;
  localparam logic [7:0] OP_BCC = 8'h90;
  localparam logic [7:0] OP_BCS = 8'hB0;
  localparam logic [7:0] OP_BNE = 8'hD0;
  localparam logic [7:0] OP_BEQ = 8'hF0;
  localparam logic [7:0] OP_CSL = 8'h54;
  localparam logic [7:0] OP_CSH = 8'hD4;

  localparam logic [2:0] GRP_AND = 3'd1;
  localparam logic [2:0] GRP_ADC = 3'd3;
  localparam logic [2:0] GRP_SBC = 3'd7;

  localparam logic [4:0] AM_ZPXI = 5'h01;
  localparam logic [4:0] AM_ZP   = 5'h05;
  localparam logic [4:0] AM_IMM  = 5'h09;
  localparam logic [4:0] AM_ABS  = 5'h0D;
  localparam logic [4:0] AM_ZPIY = 5'h11;
  localparam logic [4:0] AM_ZPI  = 5'h12;
  localparam logic [4:0] AM_ZPX  = 5'h15;
  localparam logic [4:0] AM_ABSY = 5'h19;
  localparam logic [4:0] AM_ABSX = 5'h1D;

  typedef struct packed {
    logic [7:0] res;
    logic [7:0] flags;
  } alu_out_t;

  function automatic logic alu_legal(input logic [7:0] op);
    logic [4:0] m;
    logic [2:0] g;
    logic       mode_ok;
    m = op[4:0];
    g = op[7:5];
    mode_ok = (m == AM_ZPXI) || (m == AM_ZP) || (m == AM_IMM) || (m == AM_ABS) ||
              (m == AM_ZPIY) || (m == AM_ZPI) || (m == AM_ZPX) || (m == AM_ABSY) ||
              (m == AM_ABSX);
    if (!mode_ok) return 1'b0;
    if (g == GRP_AND) return m != AM_ZPI;
    return (g == GRP_ADC) || (g == GRP_SBC);
  endfunction

  // base cycle cost; page-cross penalty added separately
  function automatic logic [3:0] alu_cycles(input logic [7:0] op);
    logic [3:0] c;
    unique case (op[4:0])
      AM_IMM:                   c = 4'd2;
      AM_ZP, AM_ZPX:            c = 4'd4;
      AM_ABS:                   c = (op[7:5] == GRP_AND) ? 4'd4 : 4'd5;
      AM_ABSX, AM_ABSY:         c = 4'd5;
      AM_ZPXI, AM_ZPIY, AM_ZPI: c = 4'd7;
      default:                  c = 4'd2;
    endcase
    return c;
  endfunction

  function automatic alu_out_t alu_calc(input logic [2:0] grp, input logic [7:0] a,
                                        input logic [7:0] v, input logic [7:0] fl);
    alu_out_t   o;
    logic [7:0] vv;
    logic [8:0] s;
    o.flags = fl;
    if (grp == GRP_AND) begin
      o.res = a & v;
    end else begin
      vv = (grp == GRP_SBC) ? ~v : v;
      s = {1'b0, a} + {1'b0, vv} + {8'd0, fl[FB_C]};
      o.res = s[7:0];
      o.flags[FB_C] = s[8];
      o.flags[FB_V] = ~(a[7] ^ vv[7]) & (a[7] ^ s[7]);
    end
    o.flags[FB_Z] = (o.res == 8'd0);
    o.flags[FB_N] = o.res[7];
    return o;
  endfunction

endpackage

[src/cpu_8bit_instruction_core_top.sv]
// CPU core top level: command sequencer, register file and 64 KiB memory
// Commands are taken when start is high and busy low; each returns one result
// flagged by out_valid for a single cycle, and the receiver cannot stall it.
// Write and PC load report through S_FIN, read through S_RB; an executed
// instruction makes each dependent access to the single-port memory in turn
// (opcode, operand bytes, pointer bytes, data, T-mode read-modify-write) and
// then reports; an execute past the cycle budget runs nothing. Memory content
// is undefined after reset; there is no clearing pass.
module cpu_8bit_instruction_core_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_byte,
  input  logic [31:0] in_cycle_limit,
  output logic        out_valid,
  output logic [7:0]  out_read_byte,
  output logic [7:0]  out_accumulator,
  output logic [7:0]  out_index_x,
  output logic [7:0]  out_index_y,
  output logic [15:0] out_program_counter,
  output logic [7:0]  out_status_flags,
  output logic [31:0] out_cycle_total,
  output logic        out_high_speed,
  output logic [31:0] out_limit_out,
  output logic        out_illegal_opcode,
  output logic        out_executed
);
  import cpu8_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIN  = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_OP   = 4'd3;
  localparam logic [3:0] S_BR   = 4'd4;
  localparam logic [3:0] S_ALO  = 4'd5;
  localparam logic [3:0] S_AHI  = 4'd6;
  localparam logic [3:0] S_ZP   = 4'd7;
  localparam logic [3:0] S_PLO  = 4'd8;
  localparam logic [3:0] S_PHI  = 4'd9;
  localparam logic [3:0] S_DATA = 4'd10;
  localparam logic [3:0] S_TM   = 4'd11;

  logic [7:0]  mem [65536];
  logic [7:0]  mem_q;
  logic [15:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;

  logic [3:0]  state_r;
  logic        valid_r;
  logic [7:0]  acc_r, x_r, y_r, fl_r, rb_r, op_r, lo_r, ptr_r, val_r;
  logic [15:0] pc_r;
  logic [31:0] cyc_r, limit_r;
  logic        speed_r, ill_r, ran_r;
  logic [3:0]  cost_r;

  logic        accept;
  logic [4:0]  am;
  logic [15:0] ea_ind;
  logic [8:0]  lo_sum;
  logic [7:0]  zp_x;
  logic        tm;
  alu_out_t    alu;
  logic [7:0]  fl_noT;
  logic        take;

  assign accept = start && !busy;
  assign am     = op_r[4:0];
  assign zp_x   = mem_q + x_r;
  assign lo_sum = {1'b0, lo_r} + {1'b0, y_r};
  assign tm     = fl_r[FB_T];
  assign fl_noT = fl_r & ~(8'd1 << FB_T);

  always_comb begin
    if (state_r == S_PHI && am == AM_ZPIY) ea_ind = {mem_q, lo_r} + {8'd0, y_r};
    else if (state_r == S_PHI)             ea_ind = {mem_q, lo_r};
    else if (am == AM_ABSY)                ea_ind = {mem_q, lo_r} + {8'd0, y_r};
    else if (am == AM_ABSX)                ea_ind = {mem_q, lo_r} + {8'd0, x_r};
    else                                   ea_ind = {mem_q, lo_r};
  end

  assign alu = (state_r == S_TM) ? alu_calc(op_r[7:5], mem_q, val_r, fl_r)
                                 : alu_calc(op_r[7:5], acc_r, mem_q, fl_r);

  always_comb begin
    unique case (mem_q)
      OP_BPL:  take = !fl_r[FB_N];
      OP_BMI:  take = fl_r[FB_N];
      OP_BVC:  take = !fl_r[FB_V];
      OP_BVS:  take = fl_r[FB_V];
      OP_BCC:  take = !fl_r[FB_C];
      OP_BCS:  take = fl_r[FB_C];
      OP_BNE:  take = !fl_r[FB_Z];
      OP_BEQ:  take = fl_r[FB_Z];
      default: take = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = alu.res;
    mem_addr = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_cmd == CMD_WRITE || in_cmd == CMD_READ) mem_addr = in_address;
        mem_we = accept && (in_cmd == CMD_WRITE);
        mem_wd = in_write_byte;
      end
      S_AHI:  mem_addr = ea_ind;
      S_ZP: begin
        if (am == AM_ZPX || am == AM_ZPXI) mem_addr = {8'd0, zp_x};
        else                               mem_addr = {8'd0, mem_q};
      end
      S_PLO:  mem_addr = {8'd0, ptr_r + 8'd1};
      S_PHI:  mem_addr = ea_ind;
      S_DATA: mem_addr = {8'd0, x_r};
      S_TM: begin
        mem_addr = {8'd0, x_r};
        mem_we   = 1'b1;
      end
      default: mem_addr = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      acc_r   <= '0;
      x_r     <= '0;
      y_r     <= '0;
      fl_r    <= '0;
      pc_r    <= '0;
      cyc_r   <= '0;
      speed_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            rb_r    <= '0;
            ill_r   <= 1'b0;
            ran_r   <= 1'b0;
            limit_r <= in_cycle_limit;
            unique case (in_cmd)
              CMD_WRITE: state_r <= S_FIN;
              CMD_READ:  state_r <= S_RB;
              CMD_LDPC: begin
                pc_r    <= in_address;
                state_r <= S_FIN;
              end
              default: begin
                if (cyc_r < in_cycle_limit) begin
                  pc_r    <= pc_r + 16'd1;
                  ran_r   <= 1'b1;
                  state_r <= S_OP;
                end else begin
                  state_r <= S_FIN;
                end
              end
            endcase
          end
        end
        S_FIN: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_RB: begin
          rb_r    <= mem_q;
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_OP: begin
          op_r    <= mem_q;
          cost_r  <= alu_cycles(mem_q);
          valid_r <= 1'b1;
          state_r <= S_IDLE;
          fl_r    <= fl_noT;
          unique case (mem_q)
            OP_SXY: begin y_r <= x_r; x_r <= y_r; cyc_r <= cyc_r + 32'd3; end
            OP_SAX: begin acc_r <= x_r; x_r <= acc_r; cyc_r <= cyc_r + 32'd3; end
            OP_SAY: begin acc_r <= y_r; y_r <= acc_r; cyc_r <= cyc_r + 32'd3; end
            OP_CLA: begin acc_r <= '0; cyc_r <= cyc_r + 32'd2; end
            OP_CLX: begin x_r <= '0; cyc_r <= cyc_r + 32'd2; end
            OP_CLY: begin y_r <= '0; cyc_r <= cyc_r + 32'd2; end
            OP_CLC: begin fl_r[FB_C] <= 1'b0; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_SEC: begin fl_r[FB_C] <= 1'b1; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_CLI: begin fl_r[FB_I] <= 1'b0; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_SEI: begin fl_r[FB_I] <= 1'b1; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_CLV: begin fl_r[FB_V] <= 1'b0; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_CLD: begin fl_r[FB_D] <= 1'b0; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_SED: begin fl_r[FB_D] <= 1'b1; fl_r[FB_T] <= 1'b0; cyc_r <= cyc_r + 32'd2; end
            OP_SET: begin fl_r[FB_T] <= 1'b1; cyc_r <= cyc_r + 32'd2; end
            OP_TAY: begin
              y_r <= acc_r;
              fl_r[FB_T] <= 1'b0;
              fl_r[FB_Z] <= (acc_r == 8'd0);
              fl_r[FB_N] <= acc_r[7];
              cyc_r <= cyc_r + 32'd2;
            end
            OP_TAX: begin
              x_r <= acc_r;
              fl_r[FB_T] <= 1'b0;
              fl_r[FB_Z] <= (acc_r == 8'd0);
              fl_r[FB_N] <= acc_r[7];
              cyc_r <= cyc_r + 32'd2;
            end
            OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
              cost_r  <= take ? 4'd4 : 4'd2;
              pc_r    <= pc_r + 16'd1;
              valid_r <= 1'b0;
              state_r <= S_BR;
            end
            OP_CSL: begin
              if (speed_r) limit_r <= {1'b0, limit_r[31:1]};
              speed_r <= 1'b0;
              cyc_r   <= cyc_r + 32'd3;
            end
            OP_CSH: begin
              if (!speed_r) limit_r <= {limit_r[30:0], 1'b0};
              speed_r <= 1'b1;
              cyc_r   <= cyc_r + 32'd3;
            end
            default: begin
              if (alu_legal(mem_q)) begin
                // T flag still needed for the operand choice; cleared at the end
                fl_r    <= fl_r;
                pc_r    <= pc_r + 16'd1;
                valid_r <= 1'b0;
                unique case (mem_q[4:0])
                  AM_IMM:                  state_r <= S_DATA;
                  AM_ABS, AM_ABSX, AM_ABSY: state_r <= S_ALO;
                  default:                 state_r <= S_ZP;
                endcase
              end else begin
                ill_r <= 1'b1;
                pc_r  <= pc_r + 16'd1;
                cyc_r <= cyc_r + 32'd2;
              end
            end
          endcase
        end
        S_BR: begin
          if (cost_r == 4'd4) pc_r <= pc_r + {{8{mem_q[7]}}, mem_q};
          cyc_r   <= cyc_r + {28'd0, cost_r};
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_ALO: begin
          lo_r    <= mem_q;
          pc_r    <= pc_r + 16'd1;
          state_r <= S_AHI;
        end
        S_AHI: state_r <= S_DATA;
        S_ZP: begin
          unique case (am)
            AM_ZP, AM_ZPX: state_r <= S_DATA;
            AM_ZPXI: begin ptr_r <= zp_x; state_r <= S_PLO; end
            default: begin ptr_r <= mem_q; state_r <= S_PLO; end
          endcase
        end
        S_PLO: begin
          lo_r    <= mem_q;
          state_r <= S_PHI;
        end
        S_PHI: begin
          if (am == AM_ZPIY && lo_sum[8]) cost_r <= cost_r + 4'd1;
          state_r <= S_DATA;
        end
        S_DATA: begin
          if (tm) begin
            val_r   <= mem_q;
            state_r <= S_TM;
          end else begin
            acc_r   <= alu.res;
            fl_r    <= alu.flags & ~(8'd1 << FB_T);
            cyc_r   <= cyc_r + {28'd0, cost_r};
            valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_TM: begin
          fl_r    <= alu.flags & ~(8'd1 << FB_T);
          cyc_r   <= cyc_r + {28'd0, cost_r};
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = valid_r;
  assign out_read_byte       = rb_r;
  assign out_accumulator     = acc_r;
  assign out_index_x         = x_r;
  assign out_index_y         = y_r;
  assign out_program_counter = pc_r;
  assign out_status_flags    = fl_r;
  assign out_cycle_total     = cyc_r;
  assign out_high_speed      = speed_r;
  assign out_limit_out       = limit_r;
  assign out_illegal_opcode  = ill_r;
  assign out_executed        = ran_r;

endmodule

[src/cpu8_checker.sv]
// Port-level checker for the CPU core, bound to the top level
`include "cpu_8bit_instruction_core_top_assert.svh"

module cpu8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_illegal_opcode,
  input logic        out_executed
);
  import cpu8_pkg::*;

  `CPU8_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request not followed by busy")
  `CPU8_ASSERT_NOW(a_valid_idle, out_valid, !busy, "result shown while busy")
  `CPU8_ASSERT_NEXT(a_single_pulse, out_valid, !out_valid, "result strobe longer than a cycle")
  `CPU8_ASSERT_NOW(a_ill_exec, out_valid && out_illegal_opcode, out_executed,
                   "illegal opcode flagged without execution")
  `CPU8_ASSERT_NEXT(a_no_exec_other, start && !busy && in_cmd != CMD_EXEC,
                    busy, "non-execute request not taken")
endmodule

bind cpu_8bit_instruction_core_top cpu8_checker u_cpu8_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
  .out_valid(out_valid), .out_illegal_opcode(out_illegal_opcode),
  .out_executed(out_executed)
);
